// File: design/stsm_pkg.sv
// Shared types and constants for the super-twisting sliding mode controller.
`timescale 1ns / 1ps
`default_nettype none

package stsm_pkg;

   localparam int FRAC       = 16;
   localparam int DIV_STEPS  = 16;
   localparam int ROOT_W     = 24;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int MUL_W      = 64;
   localparam int MP_W       = 24;
   localparam int SAT_W      = FRAC + 1;
   localparam logic [SAT_W-1:0] UNIT = SAT_W'(1) << FRAC;

   typedef enum logic [2:0] {
      REG_BOUNDARY   = 3'd0,
      REG_ROOT_GAIN  = 3'd1,
      REG_INT_GAIN   = 3'd2,
      REG_PERIOD     = 3'd3,
      REG_INT_UPPER  = 3'd4,
      REG_INT_LOWER  = 3'd5,
      REG_DRV_UPPER  = 3'd6,
      REG_DRV_LOWER  = 3'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      MUL_K1_ROOT   = 2'd0,
      MUL_BY_SAT    = 2'd1,
      MUL_K2_SAT    = 2'd2,
      MUL_BY_PERIOD = 2'd3
   } mul_op_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PREP, ST_CORE, ST_MUL_A, ST_MUL_B, ST_MUL_C, ST_MUL_D,
      ST_INTEG, ST_DRIVE
   } state_type;

   typedef struct packed {
      logic [30:0]        boundary_width;
      logic [30:0]        root_gain;
      logic [30:0]        integral_gain;
      logic [15:0]        sample_period;
      logic signed [31:0] integral_upper;
      logic signed [31:0] integral_lower;
      logic signed [31:0] drive_upper;
      logic signed [31:0] drive_lower;
   } cfg_type;

   typedef struct packed {
      logic       load;
      logic       core_start;
      logic       mul_start;
      mul_op_type mul_op;
      logic       int_update;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic core_done;
      logic mul_done;
   } status_type;

endpackage

`default_nettype wire

// File: design/stsm_if.sv
// Request and response channel interfaces.
`timescale 1ns / 1ps
`default_nettype none

interface stsm_req_if;
   logic               valid;
   logic               ready;
   logic signed [30:0] target;
   logic signed [30:0] measured;
   modport source (output valid, output target, output measured, input ready);
   modport sink (input valid, input target, input measured, output ready);
endinterface

interface stsm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] drive;
   logic               integral_frozen;
   modport source (output valid, output drive, output integral_frozen, input ready);
   modport sink (input valid, input drive, input integral_frozen, output ready);
endinterface

`default_nettype wire

// File: design/stsm_csr.sv
// APB-style configuration register file.
`timescale 1ns / 1ps
`default_nettype none

module stsm_csr import stsm_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output cfg_type          cfg
);

   cfg_type       cfg_ff, cfg_in;
   reg_index_type idx;
   logic          wr_en;

   assign idx    = reg_index_type'(paddr[4:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_BOUNDARY:  cfg_in.boundary_width = pwdata[30:0];
            REG_ROOT_GAIN: cfg_in.root_gain      = pwdata[30:0];
            REG_INT_GAIN:  cfg_in.integral_gain  = pwdata[30:0];
            REG_PERIOD:    cfg_in.sample_period  = pwdata[15:0];
            REG_INT_UPPER: cfg_in.integral_upper = pwdata;
            REG_INT_LOWER: cfg_in.integral_lower = pwdata;
            REG_DRV_UPPER: cfg_in.drive_upper    = pwdata;
            REG_DRV_LOWER: cfg_in.drive_lower    = pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_BOUNDARY:  prdata = {1'b0, cfg_ff.boundary_width};
         REG_ROOT_GAIN: prdata = {1'b0, cfg_ff.root_gain};
         REG_INT_GAIN:  prdata = {1'b0, cfg_ff.integral_gain};
         REG_PERIOD:    prdata = {16'd0, cfg_ff.sample_period};
         REG_INT_UPPER: prdata = cfg_ff.integral_upper;
         REG_INT_LOWER: prdata = cfg_ff.integral_lower;
         REG_DRV_UPPER: prdata = cfg_ff.drive_upper;
         REG_DRV_LOWER: prdata = cfg_ff.drive_lower;
         default:       prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.boundary_width <= 31'd655;
         cfg_ff.root_gain      <= 31'd0;
         cfg_ff.integral_gain  <= 31'd0;
         cfg_ff.sample_period  <= 16'd0;
         cfg_ff.integral_upper <= 32'sd65536000;
         cfg_ff.integral_lower <= -32'sd65536000;
         cfg_ff.drive_upper    <= 32'sd131072000;
         cfg_ff.drive_lower    <= -32'sd131072000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// File: design/stsm_ctrl.sv
// Sequencer for one controller tick.
`timescale 1ns / 1ps
`default_nettype none

module stsm_ctrl import stsm_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  wire logic  rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      out_free;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign rsp_valid = out_valid_ff;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.mul_op = MUL_K1_ROOT;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.core_start = 1'b1;
            state_in       = ST_CORE;
         end
         ST_CORE: begin
            if (status.core_done) begin
               cmd.mul_start = 1'b1;
               cmd.mul_op    = MUL_K1_ROOT;
               state_in      = ST_MUL_A;
            end
         end
         ST_MUL_A: begin
            if (status.mul_done) begin
               cmd.mul_start = 1'b1;
               cmd.mul_op    = MUL_BY_SAT;
               state_in      = ST_MUL_B;
            end
         end
         ST_MUL_B: begin
            if (status.mul_done) begin
               cmd.mul_start = 1'b1;
               cmd.mul_op    = MUL_K2_SAT;
               state_in      = ST_MUL_C;
            end
         end
         ST_MUL_C: begin
            if (status.mul_done) begin
               cmd.mul_start = 1'b1;
               cmd.mul_op    = MUL_BY_PERIOD;
               state_in      = ST_MUL_D;
            end
         end
         ST_MUL_D: begin
            if (status.mul_done) state_in = ST_INTEG;
         end
         ST_INTEG: begin
            cmd.int_update = 1'b1;
            state_in       = ST_DRIVE;
         end
         ST_DRIVE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.out_load) out_valid_in = 1'b1;
      else if (rsp_ready) out_valid_in = 1'b0;
      else out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

`default_nettype wire

// File: design/stsm_dp.sv
// Datapath: error, divider, square root, shift-add multiplier, integral and clamp.
`timescale 1ns / 1ps
`default_nettype none

module stsm_dp import stsm_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  cfg_type                 cfg,
   input  cmd_type                 cmd,
   output status_type              status,
   input  wire logic signed [30:0] target,
   input  wire logic signed [30:0] measured,
   output logic signed [31:0]      drive,
   output logic                    integral_frozen
);

   logic signed [31:0] s_ff;
   logic [31:0]        sabs;
   logic               in_layer;

   // divider
   logic [31:0]        div_rem_ff;
   logic [15:0]        quot_ff;
   logic [4:0]         div_cnt_ff;
   logic [32:0]        div_shift;
   logic               div_bit;
   logic [15:0]        quot_next;

   // square root, two radicand bits per step
   logic [47:0]        sq_x_ff;
   logic [25:0]        sq_rem_ff;
   logic [ROOT_W-1:0]  root_ff;
   logic [4:0]         sq_cnt_ff;
   logic [27:0]        sq_shift, sq_trial;

   logic [SAT_W-1:0]   satabs_ff;
   logic               sat_neg_ff;

   // multiplier
   logic [MUL_W-1:0]   mc_ff, prod_ff;
   logic [MP_W-1:0]    mp_ff;
   logic [39:0]        nl_mag_ff;

   logic signed [31:0] acc_ff;
   logic               freeze_ff;
   logic [31:0]        int_mag;
   logic signed [33:0] acc_sum, iup_x, ilo_x;
   logic               unfreeze, frozen_eff;

   logic signed [41:0] nl_val, drv_sum, dup_x, dlo_x;

   assign sabs     = s_ff[31] ? 32'(-s_ff) : s_ff;
   assign in_layer = sabs < {1'b0, cfg.boundary_width};

   assign div_shift = {div_rem_ff, 1'b0};
   assign div_bit   = div_shift >= {2'b00, cfg.boundary_width};
   assign quot_next = {quot_ff[14:0], div_bit};

   assign sq_shift = {sq_rem_ff, sq_x_ff[47:46]};
   assign sq_trial = {2'b00, root_ff, 2'b01};

   assign status.core_done = (div_cnt_ff == '0) && (sq_cnt_ff == '0);
   assign status.mul_done  = (mp_ff == '0);

   assign int_mag = prod_ff[FRAC+31:FRAC];
   assign iup_x   = 34'(cfg.integral_upper);
   assign ilo_x   = 34'(cfg.integral_lower);
   assign acc_sum = sat_neg_ff ? 34'(acc_ff) - $signed({2'b00, int_mag})
                               : 34'(acc_ff) + $signed({2'b00, int_mag});
   assign unfreeze = ((s_ff > 0) && (acc_ff < 0)) || ((s_ff < 0) && (acc_ff > 0))
                   || ((acc_ff < cfg.integral_upper) && (acc_ff > cfg.integral_lower));
   assign frozen_eff = freeze_ff && !unfreeze;

   assign nl_val  = sat_neg_ff ? -$signed({2'b00, nl_mag_ff}) : $signed({2'b00, nl_mag_ff});
   assign drv_sum = nl_val + 42'(acc_ff);
   assign dup_x   = 42'(cfg.drive_upper);
   assign dlo_x   = 42'(cfg.drive_lower);

   always_ff @(posedge clock) begin
      if (cmd.load) s_ff <= 32'(target) - 32'(measured);
   end

   // sat(s): divide inside the layer, unit magnitude outside
   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.core_start) begin
         div_rem_ff <= sabs;
         quot_ff    <= '0;
         if (in_layer) begin
            div_cnt_ff <= 5'(DIV_STEPS);
            sat_neg_ff <= s_ff[31];
         end else begin
            div_cnt_ff <= '0;
            satabs_ff  <= UNIT;
            sat_neg_ff <= !(s_ff > 0);
         end
      end else if (div_cnt_ff != '0) begin
         div_rem_ff <= div_bit ? 32'(div_shift - {2'b00, cfg.boundary_width})
                               : div_shift[31:0];
         quot_ff    <= quot_next;
         div_cnt_ff <= div_cnt_ff - 5'd1;
         if (div_cnt_ff == 5'd1) satabs_ff <= {1'b0, quot_next};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_cnt_ff <= '0;
      end else if (cmd.core_start) begin
         sq_x_ff   <= {sabs, 16'd0};
         sq_rem_ff <= '0;
         root_ff   <= '0;
         sq_cnt_ff <= 5'(SQRT_STEPS);
      end else if (sq_cnt_ff != '0) begin
         sq_x_ff   <= {sq_x_ff[45:0], 2'b00};
         if (sq_shift >= sq_trial) begin
            sq_rem_ff <= 26'(sq_shift - sq_trial);
            root_ff   <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            sq_rem_ff <= sq_shift[25:0];
            root_ff   <= {root_ff[ROOT_W-2:0], 1'b0};
         end
         sq_cnt_ff <= sq_cnt_ff - 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mp_ff <= '0;
      end else if (cmd.mul_start) begin
         prod_ff <= '0;
         case (cmd.mul_op)
            MUL_K1_ROOT: begin
               mc_ff <= MUL_W'(cfg.root_gain);
               mp_ff <= root_ff;
            end
            MUL_BY_SAT: begin
               mc_ff <= prod_ff >> FRAC;
               mp_ff <= MP_W'(satabs_ff);
            end
            MUL_K2_SAT: begin
               nl_mag_ff <= prod_ff[FRAC+39:FRAC];
               mc_ff     <= MUL_W'(cfg.integral_gain);
               mp_ff     <= MP_W'(satabs_ff);
            end
            default: begin
               mc_ff <= prod_ff >> FRAC;
               mp_ff <= MP_W'(cfg.sample_period);
            end
         endcase
      end else if (mp_ff != '0) begin
         if (mp_ff[0]) prod_ff <= prod_ff + mc_ff;
         mc_ff <= {mc_ff[MUL_W-2:0], 1'b0};
         mp_ff <= mp_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         freeze_ff <= 1'b0;
      end else if (cmd.int_update && (cfg.integral_gain != '0)) begin
         if (frozen_eff) begin
            freeze_ff <= 1'b1;
         end else if (acc_sum > iup_x) begin
            acc_ff    <= cfg.integral_upper;
            freeze_ff <= 1'b1;
         end else if (acc_sum < ilo_x) begin
            acc_ff    <= cfg.integral_lower;
            freeze_ff <= 1'b1;
         end else begin
            acc_ff    <= acc_sum[31:0];
            freeze_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (drv_sum > dup_x) drive <= cfg.drive_upper;
         else if (drv_sum < dlo_x) drive <= cfg.drive_lower;
         else drive <= drv_sum[31:0];
         integral_frozen <= freeze_ff;
      end
   end

   a_mul_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_start |-> mp_ff == '0)
      else $error("multiply started while busy");

   a_core_done_before_mul: assert property (@(posedge clock) disable iff (reset)
      (cmd.mul_start && cmd.mul_op == MUL_K1_ROOT) |-> (sq_cnt_ff == '0 && div_cnt_ff == '0))
      else $error("square root or divide still running");

   a_sat_bounded: assert property (@(posedge clock) disable iff (reset)
      (cmd.mul_start && cmd.mul_op == MUL_BY_SAT) |-> satabs_ff <= UNIT)
      else $error("saturation magnitude above one");

endmodule

`default_nettype wire

// File: design/super_twisting_sliding_mode_top.sv
// Top level of the super-twisting sliding mode controller.
// Usage:
//   req_bus carries one tick (target, measured, signed Q15.16) per transaction;
//   rsp_bus returns one transaction per tick with the clamped drive and the
//   integral freeze flag as it stands after that tick.
//   Gains, boundary layer, sample period and limits are written over the
//   APB-style port (psel/penable/pwrite/paddr/pwdata), register i at byte 4*i;
//   pready is always high and reads return the stored value.
// Timing:
//   One tick at a time. From acceptance the tick runs a setup state, the
//   24-step square root (the 16-step divide runs alongside it), four
//   shift-add multiplies that end early once the remaining multiplier bits
//   are zero, then the integral update and the drive clamp.
//   req_bus.ready is high while no tick is in progress, so a new tick can be
//   taken while the last result still waits in the output register.
// Reset clears the integral, the freeze flag, the sequencer and the output
// valid, and loads the register defaults. A stalled receiver holds the result
// in place; a finished tick then waits until the output register frees.
`timescale 1ns / 1ps
`default_nettype none

module super_twisting_sliding_mode_top import stsm_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   stsm_req_if.sink         req_bus,
   stsm_rsp_if.source       rsp_bus,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   stsm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   stsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   stsm_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .status          (status),
      .target          (req_bus.target),
      .measured        (req_bus.measured),
      .drive           (rsp_bus.drive),
      .integral_frozen (rsp_bus.integral_frozen)
   );

endmodule

`default_nettype wire
